### sv/fsr_pkg.sv
package fsr_pkg;

    localparam int ID_COUNT = 128;
    localparam int ID_BITS  = 7;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;
    localparam int Q_CW     = 3;

    localparam logic [7:0] BYTE_ERASED = 8'hff;
    localparam logic [7:0] BYTE_NUL    = 8'h00;

    localparam logic [15:0] REGION_SIZE_RST = 16'd4096;
    localparam logic [7:0]  MAGIC_A_RST     = 8'h41;
    localparam logic [7:0]  MAGIC_B_RST     = 8'h65;

    localparam logic [1:0] CFG_REGION_SIZE  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd1;
    localparam logic [1:0] CFG_MAGIC_SECOND = 2'd2;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_IN_USE  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_CORRUPT = 2'd3;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [5:0] {
        PH_MAGIC0 = 6'b000001,
        PH_MAGIC1 = 6'b000010,
        PH_FLAGS  = 6'b000100,
        PH_KEY    = 6'b001000,
        PH_VALUE  = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [6:0]  entry_id;
        logic        new_key;
        logic        record_active;
        logic [15:0] record_offset;
        logic [1:0]  scan_status;
        logic [15:0] used_bytes;
        logic [7:0]  unique_ids;
        logic [7:0]  next_free_id;
        logic        is_last;
    } t_out_beat;

    typedef struct packed {
        logic               rd_en;
        logic [ID_BITS-1:0] rd_addr;
        logic               wr_en;
        logic [ID_BITS-1:0] wr_addr;
        logic               clear;
    } t_seen_req;

endpackage

### sv/fsr_seen_mem.sv
module fsr_seen_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsr_pkg::t_seen_req i_req,
    output logic              o_seen
);
    import fsr_pkg::*;

    logic                r_mem [ID_COUNT];
    logic                r_rd_q;
    logic [ID_BITS-1:0]  r_rd_addr;
    logic [ID_COUNT-1:0] r_valid;
    logic [ID_COUNT-1:0] n_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= 1'b1;
        end
        if (i_req.rd_en) begin
            r_rd_q    <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    always_comb begin
        n_valid = i_req.clear ? '0 : r_valid;
        if (i_req.wr_en) begin
            n_valid[i_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // An entry counts only if it was written since the last restart.
    assign o_seen = r_rd_q & r_valid[r_rd_addr];

endmodule

### sv/fsr_out_queue.sv
module fsr_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push0,
    input  fsr_pkg::t_out_beat i_data0,
    input  logic               i_push1,
    input  fsr_pkg::t_out_beat i_data1,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output fsr_pkg::t_out_beat o_data
);
    import fsr_pkg::*;

    t_out_beat       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            pop;
    logic [Q_AW-1:0] wp_next;

    assign pop     = o_valid && !i_stall;
    assign wp_next = r_wp + Q_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wp_next] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(i_push0) + Q_AW'(i_push1);
            r_rp  <= r_rp + Q_AW'(pop);
            r_cnt <= r_cnt + Q_CW'(i_push0) + Q_CW'(i_push1) - Q_CW'(pop);
        end
    end

    assign o_room  = r_cnt <= Q_CW'(Q_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

endmodule

### sv/flash_env_record_scanner_unit.sv
// Channel  | Direction | Handshake             | Beat
// input    | in        | i_valid / o_stall     | i_data (t_in_beat)
// output   | out       | o_valid / i_stall     | o_data (t_out_beat)
// config   | in        | i_cfg_we              | i_cfg_idx, i_cfg_wdata
//
// One byte is accepted per cycle while o_stall is low. A byte is parsed
// from r_s1 after it is accepted, when the seen-id memory read issued at
// acceptance returns. Results go through a four-beat queue; input stalls
// only while fewer than two queue slots are free. Reset is synchronous and
// needs no clearing pass; the id table clears at once by its valid bits.
module flash_env_record_scanner_unit #(
    parameter int OFFSET_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fsr_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output fsr_pkg::t_out_beat o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata
);
    import fsr_pkg::*;

    localparam int CW = (OFFSET_BITS >= 16) ? OFFSET_BITS + 1 : 17;
    localparam logic [OFFSET_BITS-1:0] OFF_TOP = {OFFSET_BITS{1'b1}};

    logic [15:0] r_region;
    logic [7:0]  r_magic_a;
    logic [7:0]  r_magic_b;

    t_in_beat r_s1;
    logic     r_s1_valid;
    logic     accept_in;
    logic     go;
    logic     room;
    logic     seen;

    t_phase                 r_phase,    n_phase,    eff_phase;
    logic [OFFSET_BITS-1:0] r_off,      n_off,      eff_off;
    logic [7:0]             r_held,     n_held,     eff_held;
    logic [7:0]             r_distinct, n_distinct, eff_distinct;
    logic [7:0]             r_hpo,      n_hpo,      eff_hpo;
    logic [6:0]             r_id,       n_id,       eff_id;
    logic                   r_act,      n_act,      eff_act;
    logic                   r_new,      n_new,      eff_new;
    logic [OFFSET_BITS-1:0] r_head,     n_head,     eff_head;

    logic          restart;
    logic [7:0]    b;
    logic [CW-1:0] off_ext;
    logic [CW-1:0] off_p1;
    logic [CW-1:0] head_ext;
    logic          last;
    logic [7:0]    hpo_cand;
    logic          rep_v;
    logic          sum_v;
    logic [1:0]    sum_st;
    logic [15:0]   sum_used;
    logic          key_done;
    t_out_beat     rep_beat;
    t_out_beat     sum_beat;
    t_seen_req     seen_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region  <= REGION_SIZE_RST;
            r_magic_a <= MAGIC_A_RST;
            r_magic_b <= MAGIC_B_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_SIZE:  r_region  <= i_cfg_wdata;
                CFG_MAGIC_FIRST:  r_magic_a <= i_cfg_wdata[7:0];
                CFG_MAGIC_SECOND: r_magic_b <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign go        = r_s1_valid && room;
    assign o_stall   = r_s1_valid && !room;
    assign accept_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1 <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept_in || (r_s1_valid && !go);
        end
    end

    assign restart      = r_s1.first_byte;
    assign b            = r_s1.data_byte;
    assign eff_phase    = restart ? PH_MAGIC0 : r_phase;
    assign eff_off      = restart ? '0 : r_off;
    assign eff_held     = restart ? '0 : r_held;
    assign eff_distinct = restart ? '0 : r_distinct;
    assign eff_hpo      = restart ? '0 : r_hpo;
    assign eff_id       = restart ? '0 : r_id;
    assign eff_act      = restart ? 1'b0 : r_act;
    assign eff_new      = restart ? 1'b0 : r_new;
    assign eff_head     = restart ? '0 : r_head;

    assign off_ext  = CW'(eff_off);
    assign off_p1   = off_ext + CW'(1);
    assign head_ext = CW'(eff_head);
    assign last     = (off_p1 >= CW'(r_region)) || (eff_off == OFF_TOP);
    assign hpo_cand = 8'(b[6:0]) + 8'd1;

    always_comb begin
        n_phase    = eff_phase;
        n_off      = eff_off;
        n_held     = eff_held;
        n_distinct = eff_distinct;
        n_hpo      = eff_hpo;
        n_id       = eff_id;
        n_act      = eff_act;
        n_new      = eff_new;
        n_head     = eff_head;
        rep_v      = 1'b0;
        sum_v      = 1'b0;
        sum_st     = ST_EMPTY;
        sum_used   = '0;
        key_done   = 1'b0;

        if (eff_phase != PH_DONE && eff_off != OFF_TOP) begin
            n_off = eff_off + OFFSET_BITS'(1);
        end

        unique case (eff_phase)
            PH_MAGIC0: begin
                n_held  = b;
                n_phase = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                if (eff_held == BYTE_ERASED && b == BYTE_ERASED) begin
                    sum_v  = 1'b1;
                    sum_st = ST_EMPTY;
                end else if (eff_held != r_magic_a || b != r_magic_b) begin
                    sum_v  = 1'b1;
                    sum_st = ST_UNKNOWN;
                end else begin
                    n_phase = PH_FLAGS;
                    if (last) begin
                        sum_v    = 1'b1;
                        sum_st   = ST_IN_USE;
                        sum_used = off_p1[15:0];
                    end
                end
            end
            PH_FLAGS: begin
                if (b == BYTE_ERASED) begin
                    sum_v    = 1'b1;
                    sum_st   = ST_IN_USE;
                    sum_used = off_ext[15:0];
                end else begin
                    n_id    = b[6:0];
                    n_act   = b[7];
                    n_head  = eff_off;
                    n_new   = !seen;
                    n_phase = seen ? PH_VALUE : PH_KEY;
                    if (hpo_cand > eff_hpo) begin
                        n_hpo = hpo_cand;
                    end
                    if (last) begin
                        sum_v    = 1'b1;
                        sum_st   = ST_CORRUPT;
                        sum_used = off_p1[15:0];
                    end
                end
            end
            PH_KEY: begin
                if (b == BYTE_ERASED) begin
                    sum_v    = 1'b1;
                    sum_st   = ST_CORRUPT;
                    sum_used = off_ext[15:0];
                end else begin
                    if (b == BYTE_NUL) begin
                        key_done   = 1'b1;
                        n_distinct = eff_distinct + 8'd1;
                        n_phase    = PH_VALUE;
                    end
                    if (last) begin
                        sum_v    = 1'b1;
                        sum_st   = ST_CORRUPT;
                        sum_used = off_p1[15:0];
                    end
                end
            end
            PH_VALUE: begin
                if (b == BYTE_NUL) begin
                    rep_v   = 1'b1;
                    n_phase = PH_FLAGS;
                    if (last) begin
                        sum_v    = 1'b1;
                        sum_st   = ST_IN_USE;
                        sum_used = off_p1[15:0];
                    end
                end else if (last) begin
                    sum_v    = 1'b1;
                    sum_st   = ST_CORRUPT;
                    sum_used = off_p1[15:0];
                end
            end
            PH_DONE: ;
            default: ;
        endcase

        if (sum_v) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC0;
            r_off      <= '0;
            r_held     <= '0;
            r_distinct <= '0;
            r_hpo      <= '0;
            r_id       <= '0;
            r_act      <= 1'b0;
            r_new      <= 1'b0;
            r_head     <= '0;
        end else if (go) begin
            r_phase    <= n_phase;
            r_off      <= n_off;
            r_held     <= n_held;
            r_distinct <= n_distinct;
            r_hpo      <= n_hpo;
            r_id       <= n_id;
            r_act      <= n_act;
            r_new      <= n_new;
            r_head     <= n_head;
        end
    end

    always_comb begin
        seen_req.rd_en   = accept_in;
        seen_req.rd_addr = i_data.data_byte[6:0];
        seen_req.wr_en   = go && key_done;
        seen_req.wr_addr = eff_id;
        seen_req.clear   = go && restart;
    end

    fsr_seen_mem u_seen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seen_req),
        .o_seen  (seen)
    );

    always_comb begin
        rep_beat               = '0;
        rep_beat.kind          = KIND_REPORT;
        rep_beat.entry_id      = eff_id;
        rep_beat.new_key       = eff_new;
        rep_beat.record_active = eff_act;
        rep_beat.record_offset = head_ext[15:0];
        rep_beat.is_last       = !sum_v;

        sum_beat              = '0;
        sum_beat.kind         = KIND_SUMMARY;
        sum_beat.scan_status  = sum_st;
        sum_beat.used_bytes   = sum_used;
        sum_beat.unique_ids   = n_distinct;
        sum_beat.next_free_id = n_hpo;
        sum_beat.is_last      = 1'b1;
    end

    fsr_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (go && (rep_v || sum_v)),
        .i_data0 (rep_v ? rep_beat : sum_beat),
        .i_push1 (go && rep_v && sum_v),
        .i_data1 (sum_beat),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

### sv/fsr_checker.sv
module fsr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input fsr_pkg::t_out_beat o_data
);
    import fsr_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("Stalled output beat changed.");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_SUMMARY |->
            o_data.is_last && o_data.entry_id == '0 && !o_data.new_key &&
            !o_data.record_active && o_data.record_offset == '0)
        else $error("Summary beat carries record fields or is not last.");

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_REPORT |->
            o_data.scan_status == ST_EMPTY && o_data.used_bytes == '0 &&
            o_data.unique_ids == '0 && o_data.next_free_id == '0)
        else $error("Report beat carries summary fields.");

    a_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_SUMMARY |->
            o_data.unique_ids <= o_data.next_free_id)
        else $error("More unique ids than the next free id allows.");

    a_no_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_SUMMARY &&
            (o_data.scan_status == ST_EMPTY || o_data.scan_status == ST_UNKNOWN) |->
            o_data.used_bytes == '0 && o_data.unique_ids == '0)
        else $error("Empty or unrecognized region reports used bytes.");

endmodule

bind flash_env_record_scanner_unit fsr_checker u_fsr_checker (.*);

### tb/sv/flash_env_scan_checker.sv
module flash_env_scan_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  fsr_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  fsr_pkg::t_out_beat i_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    import fsr_pkg::*;

    t_out_beat   predicted_beats[$];
    logic [15:0] cfg_region;
    logic [7:0]  cfg_magic_a;
    logic [7:0]  cfg_magic_b;
    t_phase      scan_ph;
    logic [15:0] scan_off;
    logic [7:0]  held_byte;
    bit          seen_tab [ID_COUNT];
    logic [7:0]  distinct_ids;
    logic [7:0]  id_ceiling;
    logic [6:0]  rec_id;
    logic        rec_active;
    logic        rec_new;
    logic [15:0] rec_head;
    int          mismatches = 0;

    function automatic string beat_text(input t_out_beat x);
        return $sformatf(
            "kind=%0d id=%0d new=%0d act=%0d off=%0d st=%0d used=%0d uniq=%0d next=%0d last=%0d",
            x.kind, x.entry_id, x.new_key, x.record_active, x.record_offset,
            x.scan_status, x.used_bytes, x.unique_ids, x.next_free_id, x.is_last);
    endfunction

    task automatic restart_scan();
        scan_ph      = PH_MAGIC0;
        scan_off     = '0;
        held_byte    = '0;
        foreach (seen_tab[k]) seen_tab[k] = 1'b0;
        distinct_ids = '0;
        id_ceiling   = '0;
        rec_id       = '0;
        rec_active   = 1'b0;
        rec_new      = 1'b0;
        rec_head     = '0;
    endtask

    task automatic add_report();
        t_out_beat r;
        r               = '0;
        r.kind          = KIND_REPORT;
        r.entry_id      = rec_id;
        r.new_key       = rec_new;
        r.record_active = rec_active;
        r.record_offset = rec_head;
        predicted_beats.push_back(r);
    endtask

    task automatic add_summary(input logic [1:0] status, input logic [15:0] used);
        t_out_beat r;
        r              = '0;
        r.kind         = KIND_SUMMARY;
        r.scan_status  = status;
        r.used_bytes   = used;
        r.unique_ids   = distinct_ids;
        r.next_free_id = id_ceiling;
        predicted_beats.push_back(r);
        scan_ph = PH_DONE;
    endtask

    task automatic scan_byte(input t_in_beat beat);
        logic [7:0] b;
        logic       at_end;
        int         queued;
        b = beat.data_byte;
        if (beat.first_byte) begin
            restart_scan();
        end
        if (scan_ph == PH_DONE) begin
            return;
        end
        queued = predicted_beats.size();
        at_end = ({1'b0, scan_off} + 17'd1 >= {1'b0, cfg_region}) || (scan_off == 16'hffff);
        case (scan_ph)
            PH_MAGIC0: begin
                held_byte = b;
                scan_ph   = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                if (held_byte == BYTE_ERASED && b == BYTE_ERASED) begin
                    add_summary(ST_EMPTY, 16'd0);
                end else if (held_byte != cfg_magic_a || b != cfg_magic_b) begin
                    add_summary(ST_UNKNOWN, 16'd0);
                end else begin
                    scan_ph = PH_FLAGS;
                    if (at_end) begin
                        add_summary(ST_IN_USE, scan_off + 16'd1);
                    end
                end
            end
            PH_FLAGS: begin
                if (b == BYTE_ERASED) begin
                    add_summary(ST_IN_USE, scan_off);
                end else begin
                    rec_id     = b[6:0];
                    rec_active = b[7];
                    rec_head   = scan_off;
                    if ({1'b0, rec_id} + 8'd1 > id_ceiling) begin
                        id_ceiling = {1'b0, rec_id} + 8'd1;
                    end
                    rec_new = !seen_tab[rec_id];
                    scan_ph = rec_new ? PH_KEY : PH_VALUE;
                    if (at_end) begin
                        add_summary(ST_CORRUPT, scan_off + 16'd1);
                    end
                end
            end
            PH_KEY: begin
                if (b == BYTE_ERASED) begin
                    add_summary(ST_CORRUPT, scan_off);
                end else begin
                    if (b == BYTE_NUL) begin
                        seen_tab[rec_id] = 1'b1;
                        distinct_ids     = distinct_ids + 8'd1;
                        scan_ph          = PH_VALUE;
                    end
                    if (at_end) begin
                        add_summary(ST_CORRUPT, scan_off + 16'd1);
                    end
                end
            end
            default: begin
                if (b == BYTE_NUL) begin
                    add_report();
                    scan_ph = PH_FLAGS;
                    if (at_end) begin
                        add_summary(ST_IN_USE, scan_off + 16'd1);
                    end
                end else if (at_end) begin
                    add_summary(ST_CORRUPT, scan_off + 16'd1);
                end
            end
        endcase
        if (scan_off != 16'hffff) begin
            scan_off = scan_off + 16'd1;
        end
        if (predicted_beats.size() > queued) begin
            predicted_beats[$].is_last = 1'b1;
        end
    endtask

    task automatic check_beat(input t_out_beat got);
        t_out_beat want;
        if (predicted_beats.size() == 0) begin
            if (mismatches < 10) begin
                $display("Unexpected result beat: %s", beat_text(got));
            end
            mismatches++;
        end else begin
            want = predicted_beats.pop_front();
            if (got.kind !== want.kind || got.entry_id !== want.entry_id ||
                got.new_key !== want.new_key || got.record_active !== want.record_active ||
                got.record_offset !== want.record_offset ||
                got.scan_status !== want.scan_status || got.used_bytes !== want.used_bytes ||
                got.unique_ids !== want.unique_ids || got.next_free_id !== want.next_free_id ||
                got.is_last !== want.is_last) begin
                if (mismatches < 10) begin
                    $display("Result mismatch: expected %s", beat_text(want));
                    $display("                 actual   %s", beat_text(got));
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            predicted_beats.delete();
            cfg_region  = REGION_SIZE_RST;
            cfg_magic_a = MAGIC_A_RST;
            cfg_magic_b = MAGIC_B_RST;
            restart_scan();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REGION_SIZE:  cfg_region  = i_cfg_wdata;
                    CFG_MAGIC_FIRST:  cfg_magic_a = i_cfg_wdata[7:0];
                    CFG_MAGIC_SECOND: cfg_magic_b = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                check_beat(i_out_data);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= predicted_beats.size();
    end

endmodule

### tb/sv/tb_flash_env_record_scanner_unit.sv
module tb_flash_env_record_scanner_unit;

    import fsr_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 55;

    localparam int MARK_NONE = 0;
    localparam int MARK_HEAD = 1;
    localparam int MARK_SOME = 2;

    typedef logic [7:0] t_byte_q [$];

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    t_in_beat    i_data      = '0;
    logic        i_stall     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_beat   o_data;

    int          fail_count;
    int          pending;
    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    logic        hold_on     = 1'b0;
    event        hold_off_ev;
    logic [7:0]  cur_magic_a = MAGIC_A_RST;
    logic [7:0]  cur_magic_b = MAGIC_B_RST;

    flash_env_record_scanner_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    flash_env_scan_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end

    // The receiver holds off long enough for the result queue to fill.
    initial begin
        forever begin
            @(hold_off_ev);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, first_byte: first};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_log(input t_byte_q seq, input int mark);
        logic first;
        foreach (seq[k]) begin
            first = (k == 0 && mark != MARK_NONE) ||
                    (mark == MARK_SOME && $urandom_range(7) == 0);
            put_byte(seq[k], first);
            items_sent++;
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] region, input logic [7:0] ma,
                              input logic [7:0] mb);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_REGION_SIZE;
        i_cfg_wdata <= region;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MAGIC_FIRST;
        i_cfg_wdata <= {8'h00, ma};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MAGIC_SECOND;
        i_cfg_wdata <= {8'h00, mb};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_magic_a = ma;
        cur_magic_b = mb;
    endtask

    // One log: a header, records with random keys and values, and an ending
    // that is clean, cut short, or left open for the next restart.
    task automatic send_scan();
        t_byte_q    seq;
        bit         known_id [ID_COUNT];
        int         n_rec;
        int         r;
        logic [6:0] id;
        logic [7:0] flag;
        bit         stop;
        foreach (known_id[k]) known_id[k] = 1'b0;
        r = $urandom_range(99);
        if (r < 80) begin
            seq.push_back(cur_magic_a);
            seq.push_back(cur_magic_b);
        end else if (r < 88) begin
            seq.push_back(BYTE_ERASED);
            seq.push_back(BYTE_ERASED);
        end else if (r < 94) begin
            seq.push_back(8'($urandom()));
            seq.push_back(8'($urandom()));
        end else begin
            seq.push_back(cur_magic_a);
            seq.push_back(8'($urandom()));
        end
        n_rec = $urandom_range(8);
        stop  = 1'b0;
        for (int k = 0; k < n_rec && !stop; k++) begin
            id   = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(5));
            flag = {1'($urandom_range(1)), id};
            seq.push_back(flag);
            if (flag == BYTE_ERASED) begin
                stop = 1'b1;
            end else begin
                if (!known_id[id]) begin
                    repeat ($urandom_range(3)) seq.push_back(8'($urandom_range(254, 1)));
                    if ($urandom_range(29) == 0) begin
                        seq.push_back(BYTE_ERASED);
                        stop = 1'b1;
                    end else begin
                        seq.push_back(BYTE_NUL);
                        known_id[id] = 1'b1;
                    end
                end
                if (!stop) begin
                    repeat ($urandom_range(4)) seq.push_back(8'($urandom_range(255, 1)));
                    seq.push_back(BYTE_NUL);
                end
            end
        end
        if (!stop) begin
            r = $urandom_range(99);
            if (r < 55) begin
                seq.push_back(BYTE_ERASED);
            end else if (r < 80) begin
                seq.push_back(8'($urandom_range(254)));
                repeat ($urandom_range(3)) seq.push_back(8'($urandom_range(255, 1)));
            end
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(3, 1)) seq.push_back(8'($urandom()));
        end
        send_log(seq, MARK_HEAD);
    endtask

    initial begin
        t_byte_q     seq;
        logic [15:0] region;
        logic [7:0]  ma;
        logic [7:0]  mb;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes straight after reset are scanned without a restart mark.
        seq = '{8'h41, 8'h65, 8'h85, 8'h6b, 8'h00, 8'hff, 8'h00, 8'h05, 8'h76, 8'h00, 8'hff};
        send_log(seq, MARK_NONE);
        seq = '{8'hff, 8'hff};
        send_log(seq, MARK_HEAD);
        seq = '{8'h12};
        send_log(seq, MARK_NONE);
        seq = '{8'h41, 8'h00};
        send_log(seq, MARK_HEAD);
        seq = '{8'h41, 8'h65, 8'h7f, 8'hff};
        send_log(seq, MARK_HEAD);
        seq = '{8'h41, 8'h65, 8'h80};
        send_log(seq, MARK_HEAD);
        seq = '{8'h41, 8'h65, 8'h00, 8'h00, 8'h00, 8'hff};
        send_log(seq, MARK_HEAD);
        settle();

        set_config(16'd6, MAGIC_A_RST, MAGIC_B_RST);
        seq = '{8'h41, 8'h65, 8'h82, 8'h00, 8'h33, 8'h00};
        send_log(seq, MARK_HEAD);
        settle();
        set_config(16'd0, 8'hff, 8'h00);
        seq = '{8'hff, 8'h00, 8'hff};
        send_log(seq, MARK_HEAD);
        settle();
        set_config(16'd1, 8'h00, 8'hff);
        seq = '{8'h00, 8'hff};
        send_log(seq, MARK_HEAD);
        settle();
        set_config(16'd3, MAGIC_A_RST, MAGIC_B_RST);
        seq = '{8'h41, 8'h65, 8'h01};
        send_log(seq, MARK_HEAD);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(3))
                0:       region = 16'($urandom_range(40, 2));
                1:       region = 16'($urandom_range(200, 8));
                2:       region = REGION_SIZE_RST;
                default: region = 16'($urandom_range(65535, 2));
            endcase
            if ($urandom_range(4) == 0) begin
                ma = 8'($urandom());
                mb = 8'($urandom());
            end else begin
                ma = MAGIC_A_RST;
                mb = MAGIC_B_RST;
            end
            if (p == 0) begin
                region = REGION_SIZE_RST;
            end
            set_config(region, ma, mb);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 63; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 63; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            items_sent = 0;
            if (p == 0) begin
                -> hold_off_ev;
                seq = '{ma, mb, 8'h03, 8'h78, 8'h00, 8'h00};
                repeat (25) begin
                    seq.push_back(8'h03);
                    seq.push_back(BYTE_NUL);
                end
                seq.push_back(BYTE_ERASED);
                send_log(seq, MARK_HEAD);
            end
            while (items_sent < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    seq.delete();
                    repeat ($urandom_range(8, 1)) seq.push_back(8'($urandom()));
                    send_log(seq, MARK_SOME);
                end else begin
                    send_scan();
                end
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
